>>> src/cvg_pkg.sv
//----------------------------------------------------------------------------
// cvg_pkg
// Shared types, codes and tables of the cylinder vertex generator.
//----------------------------------------------------------------------------
`default_nettype none
package cvg_pkg;

  localparam int CORDIC_STEPS_DEF = 18;
  localparam int CFG_IDX_W        = 3;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_START     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_END       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIAL_SEGMENTS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RING_POINTS    = 3'd4;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam int DIV_STEPS = 34;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV_AX, ST_DIV_ANG, ST_ROT, ST_MUL_X, ST_MUL_Y, ST_OUT
  } state_t;

  typedef struct packed {
    logic start_load;
    logic next_load;
    logic div_step;
    logic axial_store;
    logic angle_store;
    logic rot_step;
    logic mul_x;
    logic mul_y;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic rot_done;
    logic mesh_active;
    logic out_free;
  } dp_status_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/cvg_in_if.sv
//----------------------------------------------------------------------------
// cvg_in_if
// Request channel: command and first vertex number.
//----------------------------------------------------------------------------
`default_nettype none
interface cvg_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] start_index;
  modport source (output valid, command, start_index, input ready);
  modport sink (input valid, command, start_index, output ready);
endinterface
`default_nettype wire

>>> src/cvg_out_if.sv
//----------------------------------------------------------------------------
// cvg_out_if
// Vertex channel: one generated vertex per transfer.
//----------------------------------------------------------------------------
`default_nettype none
interface cvg_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        vertex_number;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  logic signed [31:0] z_coord;
  logic [15:0]        ring_index;
  logic [15:0]        point_index;
  logic               last_vertex;
  modport source (output valid, vertex_number, x_coord, y_coord, z_coord,
                  ring_index, point_index, last_vertex, input ready);
  modport sink (input valid, vertex_number, x_coord, y_coord, z_coord,
                ring_index, point_index, last_vertex, output ready);
endinterface
`default_nettype wire

>>> src/cvg_cfg_if.sv
//----------------------------------------------------------------------------
// cvg_cfg_if
// Register write channel.
//----------------------------------------------------------------------------
`default_nettype none
interface cvg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/cvg_ctrl.sv
//----------------------------------------------------------------------------
// cvg_ctrl
// Sequencer: divider passes at start, rotation and scaling per vertex.
//----------------------------------------------------------------------------
`default_nettype none
module cvg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_command,
  output logic                req_ready,
  input  cvg_pkg::dp_status_t status,
  output cvg_pkg::ctrl_cmd_t  cmd
);
  import cvg_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req_command == CMD_START) begin
            state_next = ST_DIV_AX;
          end else if (status.mesh_active) begin
            state_next = ST_ROT;
          end
        end
      end
      ST_DIV_AX:  if (status.div_done) state_next = ST_DIV_ANG;
      ST_DIV_ANG: if (status.div_done) state_next = ST_IDLE;
      ST_ROT:     if (status.rot_done) state_next = ST_MUL_X;
      ST_MUL_X:   state_next = ST_MUL_Y;
      ST_MUL_Y:   state_next = ST_OUT;
      ST_OUT:     if (status.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    req_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.start_load = req_valid && (req_command == CMD_START);
        cmd.next_load = req_valid && (req_command == CMD_NEXT) && status.mesh_active;
      end
      ST_DIV_AX: begin
        cmd.axial_store = status.div_done;
        cmd.div_step = !status.div_done;
      end
      ST_DIV_ANG: begin
        cmd.angle_store = status.div_done;
        cmd.div_step = !status.div_done;
      end
      ST_ROT:   cmd.rot_step = !status.rot_done;
      ST_MUL_X: cmd.mul_x = 1'b1;
      ST_MUL_Y: cmd.mul_y = 1'b1;
      ST_OUT:   cmd.out_load = status.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> src/cvg_datapath.sv
//----------------------------------------------------------------------------
// cvg_datapath
// Registers, mesh counters, shared divider, CORDIC unit, radius scaling.
//----------------------------------------------------------------------------
`default_nettype none
module cvg_datapath #(
  parameter int CORDIC_STEPS = cvg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cvg_pkg::ctrl_cmd_t  cmd,
  output cvg_pkg::dp_status_t status,
  input  logic [31:0]         req_start_index,
  cvg_cfg_if.sink             cfg,
  cvg_out_if.source           vtx
);
  import cvg_pkg::*;

  localparam int RW = $clog2(CORDIC_STEPS + 1);

  logic [31:0] radius, axis_start, axis_end;
  logic [15:0] axial_segments, ring_points;

  logic [15:0]        ring_counter, point_counter;
  logic [31:0]        vertex_counter, angle_step, angle_accumulator;
  logic signed [31:0] axial_step, height_accumulator;
  logic               mesh_active;

  logic [15:0] segs, pts;
  logic [16:0] point_inc;
  logic        last;

  logic signed [32:0] diff;
  logic        diff_neg, ax_neg;
  logic [32:0] diff_mag;
  logic [33:0] num_ax, num_ang;

  logic [33:0] div_num;
  logic [16:0] div_den, div_rem;
  logic [17:0] div_shift;
  logic [5:0]  div_cnt;
  logic        div_ge;

  logic signed [33:0] cx, cy, cz, xq, yq;
  logic [1:0]         quad;
  logic [RW-1:0]      rot_cnt;
  logic signed [33:0] atan_ext;
  logic [31:0]        angle_sum;

  logic [31:0] vn_s, ring_pt_s;
  logic signed [31:0] z_s, x_res;
  logic        last_s;
  logic [63:0] prod;
  logic        prod_neg;
  logic signed [32:0] height_sum;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 32'd65536;
      axis_start <= 32'd0;
      axis_end <= 32'd65536;
      axial_segments <= 16'd1;
      ring_points <= 16'd8;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_RADIUS:         radius <= cfg.data;
        REG_AXIS_START:     axis_start <= cfg.data;
        REG_AXIS_END:       axis_end <= cfg.data;
        REG_AXIAL_SEGMENTS: axial_segments <= cfg.data[15:0];
        REG_RING_POINTS:    ring_points <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  assign segs = (axial_segments == 16'd0) ? 16'd1 : axial_segments;
  assign pts = (ring_points == 16'd0) ? 16'd1 : ring_points;
  assign point_inc = {1'b0, point_counter} + 17'd1;
  assign last = (ring_counter >= segs) && (point_inc >= {1'b0, pts});

  assign diff = {axis_end[31], axis_end} - {axis_start[31], axis_start};
  assign diff_neg = diff[32];
  assign diff_mag = diff_neg ? 33'(-diff) : 33'(diff);
  assign num_ax = {diff_mag, 1'b0} + {18'd0, segs};
  assign num_ang = {1'b1, 33'd0} + {18'd0, pts};
  assign height_sum = 33'(height_accumulator) + 33'(axial_step);

  assign div_shift = {div_rem, div_num[33]};
  assign div_ge = div_shift >= {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (cmd.start_load) begin
      div_num <= num_ax;
      div_den <= {segs, 1'b0};
      div_rem <= '0;
      ax_neg <= diff_neg;
    end else if (cmd.axial_store) begin
      div_num <= num_ang;
      div_den <= {pts, 1'b0};
      div_rem <= '0;
    end else if (cmd.div_step) begin
      div_rem <= div_ge ? 17'(div_shift - {1'b0, div_den}) : div_shift[16:0];
      div_num <= {div_num[32:0], div_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.start_load || cmd.axial_store) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_counter <= '0;
      point_counter <= '0;
      vertex_counter <= '0;
      angle_step <= '0;
      axial_step <= '0;
      angle_accumulator <= '0;
      height_accumulator <= '0;
      mesh_active <= 1'b0;
    end else if (cmd.start_load) begin
      vertex_counter <= req_start_index;
      ring_counter <= '0;
      point_counter <= '0;
      angle_accumulator <= '0;
      height_accumulator <= '0;
      mesh_active <= 1'b1;
    end else if (cmd.axial_store) begin
      if (!ax_neg) begin
        axial_step <= (div_num > 34'h07FFFFFFF) ? 32'sh7FFFFFFF : signed'(div_num[31:0]);
      end else begin
        axial_step <= (div_num > 34'h080000000) ? 32'sh80000000 : signed'(-div_num[31:0]);
      end
    end else if (cmd.angle_store) begin
      angle_step <= div_num[31:0];
    end else if (cmd.next_load) begin
      vertex_counter <= vertex_counter + 32'd1;
      if (last) begin
        mesh_active <= 1'b0;
      end else if (point_inc >= {1'b0, pts}) begin
        point_counter <= '0;
        angle_accumulator <= '0;
        ring_counter <= ring_counter + 16'd1;
        if (height_sum > 33'sh07FFFFFFF) begin
          height_accumulator <= 32'sh7FFFFFFF;
        end else if (height_sum < -33'sh080000000) begin
          height_accumulator <= 32'sh80000000;
        end else begin
          height_accumulator <= height_sum[31:0];
        end
      end else begin
        point_counter <= point_inc[15:0];
        angle_accumulator <= angle_accumulator + angle_step;
      end
    end
  end

  assign angle_sum = angle_accumulator + 32'h20000000;
  assign atan_ext = signed'({2'b00, atan_turn(5'(rot_cnt))});

  always_ff @(posedge clk) begin
    if (cmd.next_load) begin
      cx <= CORDIC_GAIN;
      cy <= '0;
      cz <= signed'({4'd0, angle_sum[29:0]}) - 34'sh20000000;
      quad <= angle_sum[31:30];
      vn_s <= vertex_counter;
      z_s <= height_accumulator;
      ring_pt_s <= {ring_counter, point_counter};
      last_s <= last;
    end else if (cmd.rot_step) begin
      if (!cz[33]) begin
        cx <= cx - (cy >>> rot_cnt);
        cy <= cy + (cx >>> rot_cnt);
        cz <= cz - atan_ext;
      end else begin
        cx <= cx + (cy >>> rot_cnt);
        cy <= cy - (cx >>> rot_cnt);
        cz <= cz + atan_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_cnt <= '0;
    end else if (cmd.next_load) begin
      rot_cnt <= '0;
    end else if (cmd.rot_step) begin
      rot_cnt <= rot_cnt + RW'(1);
    end
  end

  always_comb begin
    case (quad)
      2'd1:    begin xq = -cy; yq = cx;  end
      2'd2:    begin xq = -cx; yq = -cy; end
      2'd3:    begin xq = cy;  yq = -cx; end
      default: begin xq = cx;  yq = cy;  end
    endcase
  end

  function automatic logic [31:0] mag32(input logic signed [33:0] v);
    logic [33:0] m;
    m = v[33] ? 34'(-v) : 34'(v);
    return m[31:0];
  endfunction

  function automatic logic signed [31:0] round_sat(input logic [63:0] p, input logic neg);
    logic [64:0] s;
    logic [34:0] q;
    s = {1'b0, p} + 65'h20000000;
    q = s[64:30];
    if (!neg) begin
      return (q > 35'h07FFFFFFF) ? 32'sh7FFFFFFF : signed'(q[31:0]);
    end
    return (q > 35'h080000000) ? 32'sh80000000 : signed'(-q[31:0]);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.mul_x) begin
      prod <= radius * mag32(xq);
      prod_neg <= xq[33];
    end else if (cmd.mul_y) begin
      x_res <= round_sat(prod, prod_neg);
      prod <= radius * mag32(yq);
      prod_neg <= yq[33];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vtx.valid <= 1'b0;
    end else if (cmd.out_load) begin
      vtx.valid <= 1'b1;
    end else if (vtx.ready) begin
      vtx.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      vtx.vertex_number <= vn_s;
      vtx.x_coord <= x_res;
      vtx.y_coord <= round_sat(prod, prod_neg);
      vtx.z_coord <= z_s;
      vtx.ring_index <= ring_pt_s[31:16];
      vtx.point_index <= ring_pt_s[15:0];
      vtx.last_vertex <= last_s;
    end
  end

  assign status.div_done = (div_cnt == 6'(DIV_STEPS));
  assign status.rot_done = (rot_cnt == RW'(CORDIC_STEPS));
  assign status.mesh_active = mesh_active;
  assign status.out_free = !vtx.valid || vtx.ready;

endmodule
`default_nettype wire

>>> src/cylinder_vertex_generator.sv
//----------------------------------------------------------------------------
// cylinder_vertex_generator
// Fixed-point cylinder mesh vertex source.
//
// Channel  Dir  Payload
// req      in   command, start_index
// vtx      out  vertex_number, x/y/z_coord, ring_index, point_index, last_vertex
// cfg      in   index, data (register write)
//
// A next request is accepted, then the CORDIC unit runs CORDIC_STEPS iterations,
// one per cycle, the shared radius multiplier scales x and then y, and the
// result is loaded into vtx once vtx is free.
// A start request is accepted, then makes two 34-step passes of the shared
// divider, each followed by a store of its quotient.
// Reset clears mesh state and restores register defaults.
// A stalled vtx holds one result; the next request is still accepted.
//----------------------------------------------------------------------------
`default_nettype none
module cylinder_vertex_generator #(
  parameter int CORDIC_STEPS = cvg_pkg::CORDIC_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  cvg_in_if.sink    req,
  cvg_out_if.source vtx,
  cvg_cfg_if.sink   cfg
);
  import cvg_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  cvg_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_command (req.command),
    .req_ready   (req.ready),
    .status      (status),
    .cmd         (cmd)
  );

  cvg_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .req_start_index (req.start_index),
    .cfg             (cfg),
    .vtx             (vtx)
  );

endmodule
`default_nettype wire

>>> src/cvg_checker.sv
//----------------------------------------------------------------------------
// cvg_checker
// Port-level checks of the cylinder vertex generator.
//----------------------------------------------------------------------------
`default_nettype none
module cvg_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        vtx_valid,
  input logic        vtx_ready,
  input logic [31:0] vtx_vertex_number
);

  a_ready_after_reset: assert property (@(posedge clk) rst |=> req_ready)
    else $error("request not ready after reset");

  a_no_fast_result: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !$rose(vtx_valid))
    else $error("result one cycle after request");

  a_ready_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(vtx_valid) |-> req_ready)
    else $error("not ready when result appears");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (vtx_valid && !vtx_ready) |=> (vtx_valid && $stable(vtx_vertex_number)))
    else $error("stalled result changed");

endmodule

bind cylinder_vertex_generator cvg_checker u_cvg_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .vtx_valid         (vtx.valid),
  .vtx_ready         (vtx.ready),
  .vtx_vertex_number (vtx.vertex_number)
);
`default_nettype wire

>>> sim/cylinder_vertex_generator_tb.sv
//----------------------------------------------------------------------------
// cylinder_vertex_generator_tb
// Self-checking bench: drives start/next requests and register writes with
// random idling, predicts each vertex and compares every field.
//----------------------------------------------------------------------------
module cylinder_vertex_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cvg_pkg::*;

  typedef struct {
    logic [31:0] vertex_number;
    logic [31:0] x_coord;
    logic [31:0] y_coord;
    logic [31:0] z_coord;
    logic [15:0] ring_index;
    logic [15:0] point_index;
    logic        last_vertex;
  } vertex_t;

  class mesh_scoreboard;
    logic [31:0] radius, axis_start, axis_end;
    logic [15:0] axial_segments, ring_points;
    logic [15:0] ring_cnt, point_cnt;
    logic [31:0] vertex_cnt, angle_step, angle_acc;
    longint axial_step, height_acc;
    bit active;
    vertex_t pending[$];
    int errors;

    function new();
      radius = 32'd65536; axis_start = 0; axis_end = 32'd65536;
      axial_segments = 16'd1; ring_points = 16'd8;
      ring_cnt = 0; point_cnt = 0; vertex_cnt = 0; angle_step = 0; angle_acc = 0;
      axial_step = 0; height_acc = 0; active = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_RADIUS:         radius = d;
        REG_AXIS_START:     axis_start = d;
        REG_AXIS_END:       axis_end = d;
        REG_AXIAL_SEGMENTS: axial_segments = d[15:0];
        REG_RING_POINTS:    ring_points = d[15:0];
        default: ;
      endcase
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint floor_shift(longint v, int s);
      return v >>> s;
    endfunction

    function logic [31:0] scale(logic [31:0] r, longint c);
      bit neg;
      logic [63:0] mag, p;
      longint v;
      neg = c < 0;
      mag = neg ? -c : c;
      p = ({32'd0, r} * mag + 64'd536870912) >> 30;
      if (neg) v = -longint'((p > 64'd2147483648) ? 64'd2147483648 : p);
      else v = longint'((p > 64'd2147483647) ? 64'd2147483647 : p);
      return v[31:0];
    endfunction

    function void rotate(logic [31:0] ang, output longint cs, output longint sn);
      logic [31:0] sh;
      logic [1:0] q;
      longint x, y, z, dx, dy, t;
      sh = ang + 32'h20000000;
      q = sh[31:30];
      z = longint'({2'b0, sh[29:0]}) - 64'sd536870912;
      x = 64'sd652032874; y = 0;
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
        dx = floor_shift(y, i); dy = floor_shift(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_turn(i[4:0]));
        end else begin
          x += dx; y -= dy; z += longint'(atan_turn(i[4:0]));
        end
      end
      case (q)
        2'd1: begin t = x; x = -y; y = t; end
        2'd2: begin x = -x; y = -y; end
        2'd3: begin t = x; x = y; y = -t; end
        default: ;
      endcase
      cs = x; sn = y;
    endfunction

    function void note_request(logic cmd, logic [31:0] first);
      longint segs, pts, diff, mag, qv, cs, sn;
      bit fin;
      vertex_t v;
      segs = axial_segments ? axial_segments : 1;
      pts = ring_points ? ring_points : 1;
      if (cmd == CMD_START) begin
        diff = longint'($signed(axis_end)) - longint'($signed(axis_start));
        mag = diff < 0 ? -diff : diff;
        qv = (2 * mag + segs) / (2 * segs);
        axial_step = sat(diff < 0 ? -qv : qv);
        angle_step = 32'(((64'd1 << 33) + pts) / (2 * pts));
        vertex_cnt = first; ring_cnt = 0; point_cnt = 0;
        angle_acc = 0; height_acc = 0; active = 1;
        return;
      end
      if (!active) return;
      fin = ring_cnt >= segs && point_cnt + 1 >= pts;
      rotate(angle_acc, cs, sn);
      v.vertex_number = vertex_cnt;
      v.x_coord = scale(radius, cs);
      v.y_coord = scale(radius, sn);
      v.z_coord = height_acc[31:0];
      v.ring_index = ring_cnt;
      v.point_index = point_cnt;
      v.last_vertex = fin;
      pending.push_back(v);
      vertex_cnt++;
      if (fin) active = 0;
      else if (point_cnt + 1 >= pts) begin
        point_cnt = 0; angle_acc = 0; ring_cnt++;
        height_acc = sat(height_acc + axial_step);
      end else begin
        point_cnt++; angle_acc += angle_step;
      end
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act);
      if (exp_v !== act) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act);
        errors++;
      end
    endfunction

    function void check_vertex(vertex_t a);
      vertex_t e;
      if (pending.size() == 0) begin
        $error("unexpected vertex %0h", a.vertex_number);
        errors++;
        return;
      end
      e = pending.pop_front();
      check_field("vertex_number", e.vertex_number, a.vertex_number);
      check_field("x_coord", e.x_coord, a.x_coord);
      check_field("y_coord", e.y_coord, a.y_coord);
      check_field("z_coord", e.z_coord, a.z_coord);
      check_field("ring_index", e.ring_index, a.ring_index);
      check_field("point_index", e.point_index, a.point_index);
      check_field("last_vertex", e.last_vertex, a.last_vertex);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  bit calm = 0;
  int rx_count = 0;
  mesh_scoreboard sb = new();

  cvg_in_if req();
  cvg_out_if vtx();
  cvg_cfg_if cfg();

  cylinder_vertex_generator dut (.clk(clk), .rst(rst), .req(req), .vtx(vtx), .cfg(cfg));

  always #2 clk = ~clk;

  initial begin
    req.valid = 0; req.command = CMD_NEXT; req.start_index = 0;
    cfg.valid = 0; cfg.index = REG_RADIUS; cfg.data = 0;
    vtx.ready = 0;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stall bursts
  initial begin
    int hold;
    vertex_t a;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        hold = $urandom_range(1, 16);
        vtx.ready <= 0;
        repeat (hold) @(posedge clk);
      end
      vtx.ready <= 1;
      @(posedge clk);
      if (vtx.valid && vtx.ready) begin
        a.vertex_number = vtx.vertex_number; a.x_coord = vtx.x_coord;
        a.y_coord = vtx.y_coord; a.z_coord = vtx.z_coord;
        a.ring_index = vtx.ring_index; a.point_index = vtx.point_index;
        a.last_vertex = vtx.last_vertex;
        sb.check_vertex(a);
        rx_count++;
      end
    end
  end

  task automatic send_request(logic cmd, logic [31:0] first);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req.valid <= 1; req.command <= cmd; req.start_index <= first;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(cmd, first);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg.valid <= 1; cfg.index <= idx; cfg.data <= d;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic drain();
    req.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] r, logic [31:0] s, logic [31:0] e,
                          logic [15:0] segs, logic [15:0] pts);
    drain();
    write_reg(REG_RADIUS, r);
    write_reg(REG_AXIS_START, s);
    write_reg(REG_AXIS_END, e);
    write_reg(REG_AXIAL_SEGMENTS, {16'd0, segs});
    write_reg(REG_RING_POINTS, {16'd0, pts});
    cfg.valid <= 0;
  endtask

  task automatic random_mesh(int n);
    send_request(CMD_START, $urandom());
    for (int i = 0; i < n; i++) send_request(CMD_NEXT, $urandom());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: idle next, default mesh, restart mid-mesh, extremes
    send_request(CMD_NEXT, 32'hFFFF_FFFF);
    send_request(CMD_START, 32'hFFFF_FFFD);
    for (int i = 0; i < 6; i++) send_request(CMD_NEXT, 0);
    send_request(CMD_START, 32'd0);
    for (int i = 0; i < 18; i++) send_request(CMD_NEXT, 0);
    set_regs(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 16'd0);
    random_mesh(3);
    set_regs(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 16'd1, 16'd3);
    random_mesh(7);
    set_regs(32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF);
    random_mesh(5);
    set_regs(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'd1, 16'd1);
    random_mesh(4);
    // random phases
    for (int ph = 0; ph < 43; ph++) begin
      if (ph == 37) calm = 1;
      set_regs($urandom(), $urandom(), $urandom(), 16'($urandom_range(0, 5)),
               ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 12)));
      for (int m = 0; m < 3; m++) begin
        if ($urandom_range(0, 5) == 0) send_request(CMD_NEXT, $urandom());
        random_mesh($urandom_range(1, 20));
      end
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
